// ----- rtl/mpf_pkg.sv -----
// Shared types and constants for the monochrome page-mode frame store.
// No dependencies; imported by the channel interfaces and the core.
package mpf_pkg;

    // Field widths of the command and response words
    localparam int KIND_W   = 3;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int BANK_W   = 3;
    localparam int CELL_W   = 4;
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 4;
    localparam int BYTE_W   = 8;

    // Pixel rows covered by one byte, and the widest sprite column
    localparam int PAGE_ROWS     = 8;
    localparam int BLIT_MAX_BITS = 8;
    localparam logic [BYTE_W-1:0] INVERT_MASK = 8'hff;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_PIXEL  = 3'd2,
        KIND_INVERT = 3'd3,
        KIND_BLIT   = 3'd4,
        KIND_READ   = 3'd5
    } kind_t;

endpackage

// ----- rtl/mpf_cmd_if.sv -----
// Command channel of the frame store: valid/ready plus one command word.
// Depends on mpf_pkg for the field widths.
interface mpf_cmd_if
    import mpf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [BANK_W-1:0]   bank;
    logic [CELL_W-1:0]   cell_req;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  bit_count;

    modport source (
        output valid, kind, column, row, bank, cell_req, value, bit_count,
        input  ready
    );
    modport sink (
        input  valid, kind, column, row, bank, cell_req, value, bit_count,
        output ready
    );
endinterface

// ----- rtl/mpf_rsp_if.sv -----
// Response channel of the frame store: valid/ready plus one frame byte word.
// Depends on mpf_pkg for the field widths.
interface mpf_rsp_if
    import mpf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;

    modport source (
        output valid, frame_byte, last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last,
        output ready
    );
endinterface

// ----- rtl/mono_page_framebuffer_core.sv -----
// Frame store core for a page-organised monochrome LCD, one memory of bytes.
// A read-next word goes through the registered read port and the output register,
// which loads once rsp can take it. Per command: write byte, a write; read next, a
// read then the emit step; pixel and blit, a read-modify-write per touched byte;
// invert, a read then a write back per cell column; clear, a write to every entry;
// one read and one write port. Reset: a clearing pass zeroes the store, cmd.ready low.
module mono_page_framebuffer_core
    import mpf_pkg::*;
#(
    parameter int COLUMNS    = 84,
    parameter int BANKS      = 6,
    parameter int CELL_WIDTH = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    mpf_cmd_if.sink    cmd,
    mpf_rsp_if.source  rsp
);

    localparam int STORE_SIZE = COLUMNS * BANKS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int CNT_W      = $clog2(CELL_WIDTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam logic [7:0]        COLS_C    = 8'(COLUMNS);
    localparam logic [3:0]        BANKS_C   = 4'(BANKS);
    localparam logic [CNT_W-1:0]  CELL_C    = CNT_W'(CELL_WIDTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SWEEP  = 6'b000010,
        S_MOD_LO = 6'b000100,
        S_MOD_HI = 6'b001000,
        S_INV    = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    // Linear byte address of a bank and column
    function automatic logic [ADDR_W-1:0] lin_addr(input logic [3:0] b,
                                                   input logic [COLUMN_W-1:0] c);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(b) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(c);
        return sum[ADDR_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   addr_hi_reg, addr_hi_next;
    logic [BYTE_W-1:0]   mask_lo_reg, mask_lo_next;
    logic [BYTE_W-1:0]   data_lo_reg, data_lo_next;
    logic [BYTE_W-1:0]   mask_hi_reg, mask_hi_next;
    logic [BYTE_W-1:0]   data_hi_reg, data_hi_next;
    logic                hi_ok_reg, hi_ok_next;
    logic [7:0]          col_reg, col_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [BYTE_W-1:0]   rd_data_reg;

    logic [BYTE_W-1:0]   frame_store [STORE_SIZE];

    // Memory port controls
    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [BYTE_W-1:0]   wdata;

    // Decoded command fields
    logic                accept;
    logic                col_ok;
    logic [3:0]          lo_bank, hi_bank;
    logic [COUNT_W-1:0]  cnt_sat;
    logic [BYTE_W:0]     mask9;
    logic [BYTE_W-1:0]   mask8, data8;
    logic [2*BYTE_W-1:0] mask16, data16;
    logic [7:0]          cell_col;
    logic [7:0]          col_inc;
    logic [CNT_W-1:0]    cnt_inc;
    logic                out_load;

    assign accept   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    // Build the byte mask and data for a pixel or sprite column
    always_comb
    begin
        col_ok  = {1'b0, cmd.column} < COLS_C;
        lo_bank = {1'b0, cmd.row[ROW_W-1:3]};
        hi_bank = lo_bank + 4'd1;
        cnt_sat = (cmd.bit_count > COUNT_W'(BLIT_MAX_BITS)) ?
                  COUNT_W'(BLIT_MAX_BITS) : cmd.bit_count;
        mask9   = ((BYTE_W+1)'(1) << cnt_sat) - (BYTE_W+1)'(1);
        if (cmd.kind == KIND_PIXEL)
        begin
            mask8 = 8'h01;
            data8 = {7'b0, cmd.value[0]};
        end
        else
        begin
            mask8 = mask9[BYTE_W-1:0];
            data8 = cmd.value & mask9[BYTE_W-1:0];
        end
        mask16   = {8'b0, mask8} << cmd.row[2:0];
        data16   = {8'b0, data8} << cmd.row[2:0];
        cell_col = 8'(cmd.cell_req) * 8'(CELL_WIDTH);
        col_inc  = col_reg + 8'd1;
        cnt_inc  = cnt_reg + CNT_W'(1);
    end

    // Sequence the memory accesses of each command
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        scan_next      = scan_reg;
        addr_next      = addr_reg;
        addr_hi_next   = addr_hi_reg;
        mask_lo_next   = mask_lo_reg;
        data_lo_next   = data_lo_reg;
        mask_hi_next   = mask_hi_reg;
        data_hi_next   = data_hi_reg;
        hi_ok_next     = hi_ok_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        we    = 1'b0;
        re    = 1'b0;
        waddr = addr_reg;
        raddr = addr_reg;
        wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        KIND_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        KIND_WRITE:
                        begin
                            if (col_ok && ({1'b0, cmd.bank} < BANKS_C))
                            begin
                                we    = 1'b1;
                                waddr = lin_addr({1'b0, cmd.bank}, cmd.column);
                                wdata = cmd.value;
                            end
                        end
                        KIND_PIXEL, KIND_BLIT:
                        begin
                            if (col_ok && (lo_bank < BANKS_C) && (mask8 != '0))
                            begin
                                re           = 1'b1;
                                raddr        = lin_addr(lo_bank, cmd.column);
                                addr_next    = raddr;
                                addr_hi_next = lin_addr(hi_bank, cmd.column);
                                mask_lo_next = mask16[BYTE_W-1:0];
                                data_lo_next = data16[BYTE_W-1:0];
                                mask_hi_next = mask16[2*BYTE_W-1:BYTE_W];
                                data_hi_next = data16[2*BYTE_W-1:BYTE_W];
                                hi_ok_next   = (hi_bank < BANKS_C) &&
                                               (mask16[2*BYTE_W-1:BYTE_W] != '0);
                                state_next   = S_MOD_LO;
                            end
                        end
                        KIND_INVERT:
                        begin
                            if (({1'b0, cmd.bank} < BANKS_C) && (cell_col < COLS_C))
                            begin
                                re         = 1'b1;
                                raddr      = lin_addr({1'b0, cmd.bank},
                                                      cell_col[COLUMN_W-1:0]);
                                addr_next  = raddr;
                                col_next   = cell_col;
                                cnt_next   = '0;
                                state_next = S_INV;
                            end
                        end
                        KIND_READ:
                        begin
                            re         = 1'b1;
                            raddr      = scan_reg;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                wdata = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOD_LO:
            begin
                // Merge the low byte, fetch the byte of the next bank if needed
                we    = 1'b1;
                wdata = (rd_data_reg & ~mask_lo_reg) | data_lo_reg;
                if (hi_ok_reg)
                begin
                    re         = 1'b1;
                    raddr      = addr_hi_reg;
                    addr_next  = addr_hi_reg;
                    state_next = S_MOD_HI;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOD_HI:
            begin
                we         = 1'b1;
                wdata      = (rd_data_reg & ~mask_hi_reg) | data_hi_reg;
                state_next = S_IDLE;
            end
            S_INV:
            begin
                // Write back this column while fetching the next one
                we       = 1'b1;
                wdata    = rd_data_reg ^ INVERT_MASK;
                col_next = col_inc;
                cnt_next = cnt_inc;
                if ((cnt_inc < CELL_C) && (col_inc < COLS_C))
                begin
                    re        = 1'b1;
                    raddr     = addr_reg + ADDR_W'(1);
                    addr_next = raddr;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = rd_data_reg;
                    last_next      = (scan_reg == LAST_ADDR);
                    scan_next      = (scan_reg == LAST_ADDR) ? '0 :
                                     scan_reg + ADDR_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_store[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= frame_store[raddr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operands and output word
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        addr_hi_reg <= addr_hi_next;
        mask_lo_reg <= mask_lo_next;
        data_lo_reg <= data_lo_next;
        mask_hi_reg <= mask_hi_next;
        data_hi_reg <= data_hi_next;
        hi_ok_reg   <= hi_ok_next;
        col_reg     <= col_next;
        cnt_reg     <= cnt_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.frame_byte = byte_reg;
    assign rsp.last       = last_reg;

`ifndef SYNTHESIS
    // A read and a write never meet at one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("read and write collide on one frame store entry");

    // A read-next command always moves to the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.kind == KIND_READ)) |=> (state_reg == S_EMIT))
        else $error("read-next command did not reach the emit step");

    // The clearing pass ends on the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SWEEP) && (sweep_reg == LAST_ADDR)) |=> (state_reg == S_IDLE))
        else $error("clearing pass did not end on the last entry");

    // The scan pointer moves only when a word is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(scan_reg))
        else $error("scan pointer moved without a word");
`endif

endmodule

// ----- sim/mpf_tb_pkg.sv -----
// Testbench types, geometry and the frame store scoreboard for the page-mode core.
// Depends on mpf_pkg for field widths, the command kinds and the invert mask.
package mpf_tb_pkg;
    import mpf_pkg::*;

    // Geometry the core is built with in this bench
    localparam int COLUMNS     = 84;
    localparam int BANKS       = 6;
    localparam int CELL_WIDTH  = 6;
    localparam int STORE_BYTES = COLUMNS * BANKS;
    localparam int PIXEL_ROWS  = BANKS * PAGE_ROWS;

    // Kinds the core must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [BANK_W-1:0]   bank;
        logic [CELL_W-1:0]   cell_req;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  bit_count;
    } mpf_command_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
    } frame_word_t;

    // Shadow frame store: applies each taken command and queues the read-out words
    class frame_scoreboard;
        bit [BYTE_W-1:0] frame_model [STORE_BYTES];
        int unsigned     scan_pos;
        frame_word_t     expected_words [$];
        int unsigned     mismatches;
        int unsigned     words_checked;
        int unsigned     kind_count [8];

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // Set or clear one pixel; drop anything off screen
        function void plot_pixel(int unsigned col, int unsigned r, bit on);
            int unsigned idx;
            if (col >= COLUMNS || r >= PIXEL_ROWS)
                return;
            idx = (r / PAGE_ROWS) * COLUMNS + col;
            frame_model[idx][r % PAGE_ROWS] = on;
        endfunction

        function void note_command(mpf_command_t c);
            int unsigned i;
            int unsigned n;
            int unsigned col;
            frame_word_t w;
            kind_count[c.kind]++;
            case (c.kind)
                KIND_CLEAR:
                begin
                    foreach (frame_model[k])
                        frame_model[k] = '0;
                end
                KIND_WRITE:
                begin
                    if (c.column < COLUMNS && c.bank < BANKS)
                        frame_model[int'(c.bank) * COLUMNS + int'(c.column)] = c.value;
                end
                KIND_PIXEL:
                begin
                    plot_pixel(c.column, c.row, c.value[0]);
                end
                KIND_INVERT:
                begin
                    // flip each column of the cell that still lies on screen
                    if (c.bank < BANKS)
                    begin
                        for (i = 0; i < CELL_WIDTH; i++)
                        begin
                            col = int'(c.cell_req) * CELL_WIDTH + i;
                            if (col < COLUMNS)
                                frame_model[int'(c.bank) * COLUMNS + col] ^= INVERT_MASK;
                        end
                    end
                end
                KIND_BLIT:
                begin
                    // saturate the count, then lay the low bits downward from row
                    n = (c.bit_count > BLIT_MAX_BITS) ? BLIT_MAX_BITS : c.bit_count;
                    for (i = 0; i < n; i++)
                        plot_pixel(c.column, int'(c.row) + i, c.value[i]);
                end
                KIND_READ:
                begin
                    w.frame_byte = frame_model[scan_pos];
                    w.last       = (scan_pos == STORE_BYTES - 1);
                    expected_words.push_back(w);
                    scan_pos = (scan_pos + 1) % STORE_BYTES;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [BYTE_W-1:0] frame_byte, logic last);
            frame_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected frame word: frame_byte=%02h last=%0b", frame_byte, last);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (frame_byte !== w.frame_byte)
            begin
                $error("frame_byte: expected %02h, actual %02h", w.frame_byte, frame_byte);
                mismatches++;
            end
            if (last !== w.last)
            begin
                $error("last: expected %0b, actual %0b", w.last, last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ----- sim/tb.sv -----
// Top-level bench for mono_page_framebuffer_core: drives commands, checks read-out words.
// Depends on mpf_pkg, mpf_tb_pkg and the two channel interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpf_pkg::*;
    import mpf_tb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 32;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int STALL_AT       = 550;
    localparam int STEADY_FROM    = 800;
    localparam int STEADY_TO      = 1100;
    localparam int DRAIN_AT       = 1200;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    bit   hold_request;

    mpf_cmd_if cmd_ch ();
    mpf_rsp_if rsp_ch ();

    frame_scoreboard frame_sb = new;

    mono_page_framebuffer_core #(
        .COLUMNS    (COLUMNS),
        .BANKS      (BANKS),
        .CELL_WIDTH (CELL_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic mpf_command_t make_command(logic [KIND_W-1:0] kind,
        int unsigned column, int unsigned row, int unsigned bank,
        int unsigned cell_idx, int unsigned value, int unsigned count);
        mpf_command_t c;
        c.kind      = kind;
        c.column    = COLUMN_W'(column);
        c.row       = ROW_W'(row);
        c.bank      = BANK_W'(bank);
        c.cell_req  = CELL_W'(cell_idx);
        c.value     = VALUE_W'(value);
        c.bit_count = COUNT_W'(count);
        return c;
    endfunction

    // Offer one command word, idling at random first unless steady, and hold it until taken
    task automatic send_command(input mpf_command_t c);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= c.kind;
        cmd_ch.column    <= c.column;
        cmd_ch.row       <= c.row;
        cmd_ch.bank      <= c.bank;
        cmd_ch.cell_req  <= c.cell_req;
        cmd_ch.value     <= c.value;
        cmd_ch.bit_count <= c.bit_count;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        frame_sb.note_command(c);
    endtask

    // Lower valid and wait until every queued word has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (frame_sb.pending() != 0);
    endtask

    // Response side: check each taken word, stall at random or on request
    initial
    begin : rsp_sink
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                frame_sb.check_result(rsp_ch.frame_byte, rsp_ch.last);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        mpf_command_t c;
        int unsigned  pick;
        int unsigned  item;

        cmd_ch.valid     <= 1'b0;
        cmd_ch.kind      <= '0;
        cmd_ch.column    <= '0;
        cmd_ch.row       <= '0;
        cmd_ch.bank      <= '0;
        cmd_ch.cell_req  <= '0;
        cmd_ch.value     <= '0;
        cmd_ch.bit_count <= '0;
        rst_n            <= 1'b0;
        steady       = 1'b0;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Byte writes: in range at both corners, then off the right and bottom
        send_command(make_command(KIND_WRITE, 0, 0, 0, 0, 8'hff, 0));
        send_command(make_command(KIND_WRITE, COLUMNS - 1, 0, BANKS - 1, 0, 8'ha5, 0));
        send_command(make_command(KIND_WRITE, 127, 63, 7, 15, 8'h5a, 15));
        send_command(make_command(KIND_WRITE, COLUMNS, 0, 0, 0, 8'h3c, 0));
        send_command(make_command(KIND_WRITE, 0, 0, BANKS, 0, 8'h3c, 0));
        // Pixels: set, set and clear in the bottom corner, then off screen
        send_command(make_command(KIND_PIXEL, 1, 0, 0, 0, 8'h01, 0));
        send_command(make_command(KIND_PIXEL, COLUMNS - 1, PIXEL_ROWS - 1, 0, 0, 8'hff, 0));
        send_command(make_command(KIND_PIXEL, COLUMNS - 1, PIXEL_ROWS - 1, 0, 0, 8'hfe, 0));
        send_command(make_command(KIND_PIXEL, 127, 63, 0, 0, 8'h01, 0));
        send_command(make_command(KIND_PIXEL, 10, PIXEL_ROWS, 0, 0, 8'h01, 0));
        // Invert cells: first, last on screen, fully off screen, bank out of range
        send_command(make_command(KIND_INVERT, 0, 0, 0, 0, 0, 0));
        send_command(make_command(KIND_INVERT, 0, 0, BANKS - 1, 13, 0, 0));
        send_command(make_command(KIND_INVERT, 0, 0, 0, 15, 0, 0));
        send_command(make_command(KIND_INVERT, 0, 0, 7, 0, 0, 0));
        // Blits: clipped at the bottom, saturated count across banks, empty, off right
        send_command(make_command(KIND_BLIT, 2, PIXEL_ROWS - 4, 0, 0, 8'hff, 8));
        send_command(make_command(KIND_BLIT, 3, 5, 0, 0, 8'h81, 15));
        send_command(make_command(KIND_BLIT, 4, 0, 0, 0, 8'hff, 0));
        send_command(make_command(KIND_BLIT, 127, 0, 0, 0, 8'hff, 8));
        // Unused kinds do nothing
        send_command(make_command(KIND_UNUSED_LO, 5, 5, 0, 0, 8'hff, 8));
        send_command(make_command(KIND_UNUSED_HI, 5, 5, 0, 0, 8'hff, 8));
        // Read back the first four bytes, then clear and read on without rewinding
        repeat (4) send_command(make_command(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_command(make_command(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
        send_command(make_command(KIND_READ, 0, 0, 0, 0, 0, 0));

        // Random mix: mostly on-screen drawing and reads, some off-screen and noise
        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == STALL_AT)
                hold_request = 1'b1;
            steady = (item >= STEADY_FROM && item < STEADY_TO);
            if (item == DRAIN_AT)
                drain_results();

            c.kind      = KIND_READ;
            c.column    = COLUMN_W'($urandom_range(127));
            c.row       = ROW_W'($urandom_range(63));
            c.bank      = BANK_W'($urandom_range(7));
            c.cell_req  = CELL_W'($urandom_range(15));
            c.value     = VALUE_W'($urandom_range(255));
            c.bit_count = COUNT_W'($urandom_range(15));
            pick = $urandom_range(999);
            if (pick < 380)
            begin
                c.kind = KIND_READ;
            end
            else if (pick < 520)
            begin
                c.kind = KIND_WRITE;
                if ($urandom_range(9) < 8)
                begin
                    c.column = COLUMN_W'($urandom_range(COLUMNS - 1));
                    c.bank   = BANK_W'($urandom_range(BANKS - 1));
                end
            end
            else if (pick < 660)
            begin
                c.kind = KIND_PIXEL;
                if ($urandom_range(9) < 8)
                begin
                    c.column = COLUMN_W'($urandom_range(COLUMNS - 1));
                    c.row    = ROW_W'($urandom_range(PIXEL_ROWS - 1));
                end
            end
            else if (pick < 800)
            begin
                c.kind = KIND_BLIT;
                if ($urandom_range(9) < 8)
                    c.column = COLUMN_W'($urandom_range(COLUMNS - 1));
                if ($urandom_range(9) < 8)
                    c.bit_count = COUNT_W'($urandom_range(BLIT_MAX_BITS, 1));
                // lean on the bottom edge now and then to exercise clipping
                if ($urandom_range(3) == 0)
                    c.row = ROW_W'($urandom_range(PIXEL_ROWS - 1, PIXEL_ROWS - PAGE_ROWS));
                else if ($urandom_range(9) < 8)
                    c.row = ROW_W'($urandom_range(PIXEL_ROWS - 1));
            end
            else if (pick < 900)
            begin
                c.kind = KIND_INVERT;
                if ($urandom_range(9) < 8)
                begin
                    c.bank     = BANK_W'($urandom_range(BANKS - 1));
                    c.cell_req = CELL_W'($urandom_range((COLUMNS - 1) / CELL_WIDTH));
                end
            end
            else if (pick < 920)
            begin
                c.kind = $urandom_range(1) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
            end
            else if (pick < 928)
            begin
                c.kind = KIND_CLEAR;
            end
            else
            begin
                c.kind = KIND_W'($urandom_range(7, 1));
            end
            send_command(c);
        end
        steady = 1'b0;

        // Let the last words come back, then a short tail for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d reads, %0d writes, %0d pixels, %0d blits, %0d inverts, %0d clears,",
            frame_sb.kind_count[KIND_READ], frame_sb.kind_count[KIND_WRITE],
            frame_sb.kind_count[KIND_PIXEL], frame_sb.kind_count[KIND_BLIT],
            frame_sb.kind_count[KIND_INVERT], frame_sb.kind_count[KIND_CLEAR]);
        $display("with a long response stall and a full drain; %0d frame words checked.",
            frame_sb.words_checked);
        if (frame_sb.mismatches == 0 && frame_sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
